FILE: design/ptw_pkg.sv
// ---------------------------------------------------------------------------
// Page table walker package
// Shared types, codes and helper functions for the four-level walker.
// ---------------------------------------------------------------------------
`default_nettype none

package ptw_pkg;

	// Default physical address width kept from table entries.
	localparam int unsigned PHYS_ADDR_BITS_DEF = 52;

	// Input operation codes.
	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_SET    = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_SWAP   = 2'd3;

	// Result kinds.
	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_CAS   = 2'd1;
	localparam logic [1:0] KIND_INVAL = 2'd2;
	localparam logic [1:0] KIND_DONE  = 2'd3;

	// Completion status codes.
	localparam logic [3:0] ST_XLATED    = 4'd0;
	localparam logic [3:0] ST_LEAF_2M   = 4'd1;
	localparam logic [3:0] ST_LEAF_1G   = 4'd2;
	localparam logic [3:0] ST_NOT_PRES  = 4'd3;
	localparam logic [3:0] ST_RANGE     = 4'd4;
	localparam logic [3:0] ST_BAD_BASE  = 4'd5;
	localparam logic [3:0] ST_SET       = 4'd6;
	localparam logic [3:0] ST_SWAP_FAIL = 4'd7;
	localparam logic [3:0] ST_BUSY      = 4'd8;

	// Page size codes.
	localparam logic [1:0] PSZ_4K = 2'd0;
	localparam logic [1:0] PSZ_2M = 2'd1;
	localparam logic [1:0] PSZ_1G = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_TABLE_BASE = 2'd0;
	localparam logic [1:0] CFG_USER_START = 2'd1;
	localparam logic [1:0] CFG_USER_END   = 2'd2;

	// Entry bit constants.
	localparam logic [63:0] ENTRY_CLEAR = 64'h8000_0000_0000_0007;
	localparam logic [63:0] ENTRY_PS    = 64'h0000_0000_0000_0080;
	localparam logic [63:0] PAGE_4K_OFS = 64'h0000_0000_0000_0FFF;
	localparam logic [63:0] PAGE_2M_OFS = 64'h0000_0000_001F_FFFF;
	localparam logic [8:0]  IDX_MASK    = 9'h1FF;

	// One input item.
	typedef struct packed {
		logic [1:0]  op;
		logic [63:0] vaddr;
		logic [63:0] flags;
		logic [63:0] mdata;
	} item_t;

	// One result item.
	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] target_addr;
		logic [63:0] write_data;
		logic [63:0] expected_data;
		logic [3:0]  status;
		logic [1:0]  fault_level;
		logic [1:0]  page_size;
		logic [51:0] paddr;
		logic [63:0] leaf_entry;
		logic        last;
	} result_t;

	// Results produced by the walker core for the item in its stage.
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} core_res_t;

	// Configuration register values.
	typedef struct packed {
		logic [51:0] table_base;
		logic [63:0] user_start;
		logic [63:0] user_end;
	} cfg_t;

	// Address of the entry for a level: table bits masked, index from the vaddr.
	function automatic logic [63:0] entry_addr(input logic [63:0] tbl,
			input logic [63:0] va, input logic [1:0] lvl, input logic [63:0] mask);
		logic [8:0] idx;
		case (lvl)
			2'd0: idx = va[47:39];
			2'd1: idx = va[38:30];
			2'd2: idx = va[29:21];
			default: idx = va[20:12];
		endcase
		return (tbl & mask) | {52'd0, idx & IDX_MASK, 3'd0};
	endfunction

	// Build a result item.
	function automatic result_t mk_res(input logic [1:0] kind,
			input logic [63:0] target, input logic [63:0] wdata,
			input logic [63:0] expd, input logic [3:0] status,
			input logic [1:0] lvl, input logic [1:0] psize,
			input logic [51:0] phys, input logic [63:0] leaf, input logic last);
		result_t r;
		r.kind          = kind;
		r.target_addr   = target;
		r.write_data    = wdata;
		r.expected_data = expd;
		r.status        = status;
		r.fault_level   = lvl;
		r.page_size     = psize;
		r.paddr         = phys;
		r.leaf_entry    = leaf;
		r.last          = last;
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: design/page_table_walker_with_permission_update_top.sv
// ---------------------------------------------------------------------------
// Page table walker with permission update
// Four-level page table walker that issues entry reads and permission swaps.
// ---------------------------------------------------------------------------
// Requests (lookup, set-permission) and memory responses (table read, swap)
// arrive on the s_axis channel; tuser carries the operation. Each accepted
// request goes into an input register, is decoded against the walk state,
// and its results go into a two-entry result queue that drives m_axis; tuser
// carries the result kind and tlast marks the final result. A result reaches
// m_axis through the input register and then the result queue register.
// Throughput is one request per cycle: a request yielding one result moves
// on whenever a queue slot is free. A successful swap response yields an
// invalidate followed by a completion and waits until both slots are free.
// Configuration writes on the cfg channel are always taken and should only
// be made while the walker is idle. Reset clears the configuration
// registers to zero, puts the walker in its idle phase and empties the
// queue. When the receiver stalls, the queue fills, the input register
// holds its request and s_axis_tready drops.
// ---------------------------------------------------------------------------
`default_nettype none

module page_table_walker_with_permission_update_top #(
	parameter int unsigned PHYS_ADDR_BITS = ptw_pkg::PHYS_ADDR_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Request stream
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// tdata: vaddr[63:0], perm_flags[127:64], mem_data[191:128]
	input  wire logic [191:0] s_axis_tdata,
	// tuser: operation[1:0]
	input  wire logic [1:0]   s_axis_tuser,
	// Result stream
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// tdata: target_addr[63:0], write_data[127:64], expected_data[191:128],
	// status[195:192], fault_level[197:196], page_size[199:198],
	// paddr[251:200], leaf_entry[315:252], zero[319:316]
	output logic [319:0]      m_axis_tdata,
	// tuser: kind[1:0]
	output logic [1:0]        m_axis_tuser,
	output logic              m_axis_tlast,
	// Configuration writes
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [63:0]  cfg_data
);

	ptw_pkg::cfg_t      cfg_q;
	ptw_pkg::item_t     item_s1;
	logic               valid_s1;
	logic               adv;
	logic [1:0]         free;
	ptw_pkg::core_res_t res;
	ptw_pkg::result_t   head;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ptw_pkg::CFG_TABLE_BASE: cfg_q.table_base <= cfg_data[51:0];
				ptw_pkg::CFG_USER_START: cfg_q.user_start <= cfg_data;
				ptw_pkg::CFG_USER_END:   cfg_q.user_end   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register; the request moves on once the queue has room for it.
	assign adv           = valid_s1 && (res.count <= free);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.op    <= s_axis_tuser;
			item_s1.vaddr <= s_axis_tdata[63:0];
			item_s1.flags <= s_axis_tdata[127:64];
			item_s1.mdata <= s_axis_tdata[191:128];
		end
	end

	ptw_core #(
		.PHYS_ADDR_BITS(PHYS_ADDR_BITS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_s1),
		.fire  (adv),
		.cfg   (cfg_q),
		.res   (res)
	);

	ptw_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (adv),
		.res       (res),
		.pop_ready (m_axis_tready),
		.head_valid(m_axis_tvalid),
		.head      (head),
		.free      (free)
	);

	// Result packing.
	assign m_axis_tuser = head.kind;
	assign m_axis_tlast = head.last;
	assign m_axis_tdata = {4'd0, head.leaf_entry, head.paddr, head.page_size,
	                       head.fault_level, head.status, head.expected_data,
	                       head.write_data, head.target_addr};

`ifndef SYNTHESIS
	// An invalidate is always followed directly by its completion.
	a_inval_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tuser == ptw_pkg::KIND_INVAL)
		|=> (m_axis_tvalid && m_axis_tuser == ptw_pkg::KIND_DONE && m_axis_tlast))
		else $error("invalidate not followed by its completion");

	// A request that cannot move on stays in the input register unchanged.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(item_s1)))
		else $error("input register lost a waiting request");

	// Entry reads and swaps always target an eight-byte aligned entry.
	a_entry_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res.count != 2'd0 &&
		(res.r0.kind == ptw_pkg::KIND_READ || res.r0.kind == ptw_pkg::KIND_CAS))
		|-> (res.r0.target_addr[2:0] == 3'd0))
		else $error("misaligned entry address");
`endif

endmodule

`default_nettype wire

FILE: design/ptw_core.sv
// ---------------------------------------------------------------------------
// Page table walker core
// Decodes one item against the walk state and updates that state.
// ---------------------------------------------------------------------------
`default_nettype none

module ptw_core #(
	parameter int unsigned PHYS_ADDR_BITS = ptw_pkg::PHYS_ADDR_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ptw_pkg::item_t    item,
	input  wire logic              fire,
	input  wire ptw_pkg::cfg_t     cfg,
	output ptw_pkg::core_res_t     res
);

	localparam logic [63:0] AddrMask =
		((64'd1 << PHYS_ADDR_BITS) - 64'd1) & ~ptw_pkg::PAGE_4K_OFS;

	typedef enum logic [5:0] {
		PH_IDLE = 6'b000001,
		PH_RD0  = 6'b000010,
		PH_RD1  = 6'b000100,
		PH_RD2  = 6'b001000,
		PH_RD3  = 6'b010000,
		PH_SWAP = 6'b100000
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [63:0] vaddr_q, vaddr_n;
	logic [63:0] flags_q, flags_n;
	logic        is_set_q, is_set_n;
	logic [63:0] entry_q, entry_n;
	logic        large_q, large_n;

	logic [1:0]  lvl;
	logic        rd_wait;
	logic        ps;
	logic        present;
	logic [63:0] base_m;
	logic [63:0] pa;
	logic [63:0] cas_data;
	logic [63:0] page;
	logic [1:0]  psz_sw;
	logic [1:0]  lvl_sw;
	phase_t      phase_nx;

	// Level being read and the phase that follows it.
	always_comb begin
		case (phase_q)
			PH_RD0: begin
				lvl = 2'd0;
				phase_nx = PH_RD1;
			end
			PH_RD1: begin
				lvl = 2'd1;
				phase_nx = PH_RD2;
			end
			PH_RD2: begin
				lvl = 2'd2;
				phase_nx = PH_RD3;
			end
			PH_RD3: begin
				lvl = 2'd3;
				phase_nx = PH_IDLE;
			end
			default: begin
				lvl = 2'd0;
				phase_nx = PH_IDLE;
			end
		endcase
	end

	assign rd_wait   = (phase_q == PH_RD0) || (phase_q == PH_RD1) ||
	                   (phase_q == PH_RD2) || (phase_q == PH_RD3);
	assign ps        = item.mdata[7];
	assign present   = item.mdata[0];
	assign base_m    = {12'd0, cfg.table_base} & AddrMask;
	assign pa        = (item.mdata & AddrMask) | (vaddr_q & ptw_pkg::PAGE_4K_OFS);
	assign cas_data  = (item.mdata & ~ptw_pkg::ENTRY_CLEAR) | flags_q |
	                   ((lvl == 2'd2) ? ptw_pkg::ENTRY_PS : 64'd0);
	assign page      = large_q ? (vaddr_q & ~ptw_pkg::PAGE_2M_OFS)
	                           : (vaddr_q & ~ptw_pkg::PAGE_4K_OFS);
	assign psz_sw    = large_q ? ptw_pkg::PSZ_2M : ptw_pkg::PSZ_4K;
	assign lvl_sw    = large_q ? 2'd2 : 2'd3;

	// Result and next state for the item in the stage.
	always_comb begin
		res      = '0;
		phase_n  = phase_q;
		vaddr_n  = vaddr_q;
		flags_n  = flags_q;
		is_set_n = is_set_q;
		entry_n  = entry_q;
		large_n  = large_q;
		case (item.op)
			ptw_pkg::OP_LOOKUP, ptw_pkg::OP_SET: begin
				res.count = 2'd1;
				if (phase_q != PH_IDLE) begin
					res.r0 = ptw_pkg::mk_res(ptw_pkg::KIND_DONE, '0, '0, '0,
						ptw_pkg::ST_BUSY, 2'd0, ptw_pkg::PSZ_4K, '0, '0, 1'b1);
				end else if (item.op == ptw_pkg::OP_SET &&
						(item.vaddr < cfg.user_start || item.vaddr >= cfg.user_end)) begin
					res.r0 = ptw_pkg::mk_res(ptw_pkg::KIND_DONE, '0, '0, '0,
						ptw_pkg::ST_RANGE, 2'd0, ptw_pkg::PSZ_4K, '0, '0, 1'b1);
				end else if (item.op == ptw_pkg::OP_SET && base_m == 64'd0) begin
					res.r0 = ptw_pkg::mk_res(ptw_pkg::KIND_DONE, '0, '0, '0,
						ptw_pkg::ST_BAD_BASE, 2'd0, ptw_pkg::PSZ_4K, '0, '0, 1'b1);
				end else begin
					vaddr_n  = item.vaddr;
					flags_n  = item.flags;
					is_set_n = (item.op == ptw_pkg::OP_SET);
					entry_n  = {12'd0, cfg.table_base};
					large_n  = 1'b0;
					phase_n  = PH_RD0;
					res.r0 = ptw_pkg::mk_res(ptw_pkg::KIND_READ,
						ptw_pkg::entry_addr({12'd0, cfg.table_base}, item.vaddr, 2'd0,
						AddrMask), '0, '0, ptw_pkg::ST_XLATED, 2'd0, ptw_pkg::PSZ_4K,
						'0, '0, 1'b1);
				end
			end
			ptw_pkg::OP_READ: begin
				if (rd_wait) begin
					res.count = 2'd1;
					if (!present) begin
						phase_n = PH_IDLE;
						res.r0 = ptw_pkg::mk_res(ptw_pkg::KIND_DONE, '0, '0, '0,
							ptw_pkg::ST_NOT_PRES, lvl, ptw_pkg::PSZ_4K, '0, item.mdata, 1'b1);
					end else if (lvl == 2'd1 && ps) begin
						phase_n = PH_IDLE;
						res.r0 = ptw_pkg::mk_res(ptw_pkg::KIND_DONE, '0, '0, '0,
							ptw_pkg::ST_LEAF_1G, 2'd1, ptw_pkg::PSZ_1G, '0, item.mdata, 1'b1);
					end else if ((lvl == 2'd2 && ps) || lvl == 2'd3) begin
						if (!is_set_q) begin
							phase_n = PH_IDLE;
							if (lvl == 2'd2) begin
								res.r0 = ptw_pkg::mk_res(ptw_pkg::KIND_DONE, '0, '0, '0,
									ptw_pkg::ST_LEAF_2M, 2'd2, ptw_pkg::PSZ_2M, '0,
									item.mdata, 1'b1);
							end else begin
								res.r0 = ptw_pkg::mk_res(ptw_pkg::KIND_DONE, '0, '0, '0,
									ptw_pkg::ST_XLATED, 2'd3, ptw_pkg::PSZ_4K, pa[51:0],
									item.mdata, 1'b1);
							end
						end else begin
							large_n = (lvl == 2'd2);
							entry_n = item.mdata;
							phase_n = PH_SWAP;
							res.r0 = ptw_pkg::mk_res(ptw_pkg::KIND_CAS,
								ptw_pkg::entry_addr(entry_q, vaddr_q, lvl, AddrMask),
								cas_data, item.mdata, ptw_pkg::ST_XLATED, lvl,
								(lvl == 2'd2) ? ptw_pkg::PSZ_2M : ptw_pkg::PSZ_4K, '0,
								item.mdata, 1'b1);
						end
					end else begin
						// Descend to the next table.
						entry_n = item.mdata;
						phase_n = phase_nx;
						res.r0 = ptw_pkg::mk_res(ptw_pkg::KIND_READ,
							ptw_pkg::entry_addr(item.mdata, vaddr_q, lvl + 2'd1, AddrMask),
							'0, '0, ptw_pkg::ST_XLATED, 2'd0, ptw_pkg::PSZ_4K, '0, '0, 1'b1);
					end
				end
			end
			ptw_pkg::OP_SWAP: begin
				if (phase_q == PH_SWAP) begin
					phase_n = PH_IDLE;
					if (item.mdata == entry_q) begin
						res.count = 2'd2;
						res.r0 = ptw_pkg::mk_res(ptw_pkg::KIND_INVAL, page, '0, '0,
							ptw_pkg::ST_XLATED, 2'd0, psz_sw, '0, '0, 1'b0);
						res.r1 = ptw_pkg::mk_res(ptw_pkg::KIND_DONE, '0, '0, '0,
							ptw_pkg::ST_SET, lvl_sw, psz_sw, '0, entry_q, 1'b1);
					end else begin
						res.count = 2'd1;
						res.r0 = ptw_pkg::mk_res(ptw_pkg::KIND_DONE, '0, '0, '0,
							ptw_pkg::ST_SWAP_FAIL, lvl_sw, psz_sw, '0, entry_q, 1'b1);
					end
				end
			end
			default: begin
				res.count = 2'd0;
			end
		endcase
	end

	// Walk state, updated when the item leaves the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			vaddr_q  <= '0;
			flags_q  <= '0;
			is_set_q <= 1'b0;
			entry_q  <= '0;
			large_q  <= 1'b0;
		end else if (fire) begin
			phase_q  <= phase_n;
			vaddr_q  <= vaddr_n;
			flags_q  <= flags_n;
			is_set_q <= is_set_n;
			entry_q  <= entry_n;
			large_q  <= large_n;
		end
	end

endmodule

`default_nettype wire

FILE: design/ptw_out_queue.sv
// ---------------------------------------------------------------------------
// Page table walker result queue
// Two-entry result register that takes up to two results in one cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module ptw_out_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire ptw_pkg::core_res_t  res,
	input  wire logic                pop_ready,
	output logic                     head_valid,
	output ptw_pkg::result_t         head,
	output logic [1:0]               free
);

	ptw_pkg::result_t slot0_q, slot1_q;
	ptw_pkg::result_t slot0_n, slot1_n, slot0_ap;
	logic [1:0]       count_q;
	logic [1:0]       cnt_ap;
	logic [1:0]       n_push;
	logic             pop;

	assign head_valid = (count_q != 2'd0);
	assign head       = slot0_q;
	assign free       = 2'd2 - count_q;
	assign pop        = head_valid && pop_ready;
	assign n_push     = push ? res.count : 2'd0;

	// Shift out the head, then place new results behind what remains.
	always_comb begin
		cnt_ap   = count_q - {1'b0, pop};
		slot0_ap = pop ? slot1_q : slot0_q;
		slot0_n  = slot0_ap;
		slot1_n  = slot1_q;
		if (n_push != 2'd0 && cnt_ap == 2'd0) begin
			slot0_n = res.r0;
		end
		if (n_push == 2'd2) begin
			slot1_n = res.r1;
		end else if (n_push == 2'd1 && cnt_ap == 2'd1) begin
			slot1_n = res.r0;
		end
	end

	// Occupancy count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= cnt_ap + n_push;
		end
	end

	// Result slots.
	always_ff @(posedge clk) begin
		slot0_q <= slot0_n;
		slot1_q <= slot1_n;
	end

endmodule

`default_nettype wire

FILE: dv/ptw_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Page table walker checker
// Watches the request, result and configuration channels of the walker,
// predicts every result from its own copy of the walk state and compares
// the results on m_axis field by field, in order.
// ---------------------------------------------------------------------------

module ptw_checker #(
	parameter int unsigned PHYS_ADDR_BITS = ptw_pkg::PHYS_ADDR_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	input  wire logic         s_axis_tready,
	input  wire logic [191:0] s_axis_tdata,
	input  wire logic [1:0]   s_axis_tuser,
	input  wire logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	input  wire logic [319:0] m_axis_tdata,
	input  wire logic [1:0]   m_axis_tuser,
	input  wire logic         m_axis_tlast,
	input  wire logic         cfg_valid,
	input  wire logic         cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [63:0]  cfg_data,
	output int                mismatches,
	output int                results_checked,
	output int                pending,
	output logic              walk_busy,
	output logic              swap_wait
);

	// Walk phases: idle, waiting for the read of level 0 to 3, waiting for the swap.
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_LEVEL0 = 3'd1;
	localparam logic [2:0] PH_LEVEL3 = 3'd4;
	localparam logic [2:0] PH_SWAP   = 3'd5;

	localparam logic [63:0] ADDR_MASK = ((64'd1 << PHYS_ADDR_BITS) - 64'd1) & ~64'hFFF;

	// Configuration and walk state as the walker should hold them.
	logic [51:0] table_base;
	logic [63:0] user_start;
	logic [63:0] user_end;
	logic [2:0]  phase;
	logic [63:0] held_vaddr;
	logic [63:0] held_flags;
	logic        set_req;
	logic [63:0] held_entry;
	logic        leaf_large;

	// Results still owed by the walker, oldest first.
	ptw_pkg::result_t expected_q[$];

	// Entry address for a level: table bits of the entry, index from the vaddr.
	function automatic logic [63:0] entry_ptr(input logic [63:0] tbl, input logic [63:0] va,
			input logic [1:0] lvl);
		logic [8:0] idx;
		idx = va[(39 - 9 * int'(lvl)) +: 9];
		return (tbl & ADDR_MASK) | {52'd0, idx, 3'd0};
	endfunction

	// Work out the results of one accepted request and advance the walk state.
	task automatic predict_walk(input logic [1:0] op, input logic [63:0] va,
			input logic [63:0] fl, input logic [63:0] md);
		ptw_pkg::result_t r;
		ptw_pkg::result_t inval;
		logic [1:0] lvl;
		logic ps;
		logic big_leaf;
		logic [63:0] nv;
		r = '0;
		r.last = 1'b1;
		inval = '0;
		ps = md[7];
		lvl = 2'(phase - PH_LEVEL0);
		case (op)
			ptw_pkg::OP_LOOKUP, ptw_pkg::OP_SET: begin
				r.kind = ptw_pkg::KIND_DONE;
				if (phase != PH_IDLE) begin
					r.status = ptw_pkg::ST_BUSY;
				end else if (op == ptw_pkg::OP_SET && (va < user_start || va >= user_end)) begin
					r.status = ptw_pkg::ST_RANGE;
				end else if (op == ptw_pkg::OP_SET &&
						({12'd0, table_base} & ADDR_MASK) == 64'd0) begin
					r.status = ptw_pkg::ST_BAD_BASE;
				end else begin
					held_vaddr = va;
					held_flags = fl;
					set_req = (op == ptw_pkg::OP_SET);
					held_entry = {12'd0, table_base};
					leaf_large = 1'b0;
					phase = PH_LEVEL0;
					r.kind = ptw_pkg::KIND_READ;
					r.target_addr = entry_ptr({12'd0, table_base}, va, 2'd0);
				end
				expected_q.push_back(r);
			end
			ptw_pkg::OP_READ: begin
				if (phase >= PH_LEVEL0 && phase <= PH_LEVEL3) begin
					r.kind = ptw_pkg::KIND_DONE;
					if (!md[0]) begin
						// Entry not present: the walk stops at this level.
						phase = PH_IDLE;
						r.status = ptw_pkg::ST_NOT_PRES;
						r.fault_level = lvl;
						r.leaf_entry = md;
					end else if (lvl == 2'd1 && ps) begin
						// 1GB leaf: reported, never rewritten.
						phase = PH_IDLE;
						r.status = ptw_pkg::ST_LEAF_1G;
						r.fault_level = lvl;
						r.page_size = ptw_pkg::PSZ_1G;
						r.leaf_entry = md;
					end else if ((lvl == 2'd2 && ps) || lvl == 2'd3) begin
						big_leaf = (lvl == 2'd2);
						if (!set_req) begin
							phase = PH_IDLE;
							r.status = big_leaf ? ptw_pkg::ST_LEAF_2M : ptw_pkg::ST_XLATED;
							r.fault_level = lvl;
							r.page_size = big_leaf ? ptw_pkg::PSZ_2M : ptw_pkg::PSZ_4K;
							r.leaf_entry = md;
							if (!big_leaf) begin
								r.paddr = 52'((md & ADDR_MASK) | (held_vaddr & 64'hFFF));
							end
						end else begin
							// Set request at a 2MB or 4KB leaf: rewrite with a swap.
							nv = (md & ~ptw_pkg::ENTRY_CLEAR) | held_flags;
							if (big_leaf) begin
								nv = nv | ptw_pkg::ENTRY_PS;
							end
							r.kind = ptw_pkg::KIND_CAS;
							r.target_addr = entry_ptr(held_entry, held_vaddr, lvl);
							r.write_data = nv;
							r.expected_data = md;
							r.fault_level = lvl;
							r.page_size = big_leaf ? ptw_pkg::PSZ_2M : ptw_pkg::PSZ_4K;
							r.leaf_entry = md;
							leaf_large = big_leaf;
							held_entry = md;
							phase = PH_SWAP;
						end
					end else begin
						// Table entry: read the next level.
						r.kind = ptw_pkg::KIND_READ;
						r.target_addr = entry_ptr(md, held_vaddr, lvl + 2'd1);
						held_entry = md;
						phase = phase + 3'd1;
					end
					expected_q.push_back(r);
				end
			end
			default: begin
				if (phase == PH_SWAP) begin
					phase = PH_IDLE;
					r.kind = ptw_pkg::KIND_DONE;
					r.fault_level = leaf_large ? 2'd2 : 2'd3;
					r.page_size = leaf_large ? ptw_pkg::PSZ_2M : ptw_pkg::PSZ_4K;
					r.leaf_entry = held_entry;
					if (md == held_entry) begin
						// Swap took effect: invalidate the page, then complete.
						inval.kind = ptw_pkg::KIND_INVAL;
						inval.target_addr = held_vaddr &
							~(leaf_large ? ptw_pkg::PAGE_2M_OFS : ptw_pkg::PAGE_4K_OFS);
						inval.page_size = r.page_size;
						expected_q.push_back(inval);
						r.status = ptw_pkg::ST_SET;
					end else begin
						r.status = ptw_pkg::ST_SWAP_FAIL;
					end
					expected_q.push_back(r);
				end
			end
		endcase
	endtask

	// Print one line per mismatch and count it.
	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		$display("%0t: result %0d: %s got %h, expected %h", $time, results_checked, what,
			got, want);
	endtask

	// Compare the result on m_axis with the oldest expectation.
	task automatic check_result();
		ptw_pkg::result_t want;
		if (expected_q.size() == 0) begin
			report_mismatch("unexpected result, kind", 64'(m_axis_tuser), 64'd0);
		end else begin
			want = expected_q.pop_front();
			if (m_axis_tuser !== want.kind)
				report_mismatch("kind", 64'(m_axis_tuser), 64'(want.kind));
			if (m_axis_tdata[63:0] !== want.target_addr)
				report_mismatch("target_addr", m_axis_tdata[63:0], want.target_addr);
			if (m_axis_tdata[127:64] !== want.write_data)
				report_mismatch("write_data", m_axis_tdata[127:64], want.write_data);
			if (m_axis_tdata[191:128] !== want.expected_data)
				report_mismatch("expected_data", m_axis_tdata[191:128], want.expected_data);
			if (m_axis_tdata[195:192] !== want.status)
				report_mismatch("status", 64'(m_axis_tdata[195:192]), 64'(want.status));
			if (m_axis_tdata[197:196] !== want.fault_level)
				report_mismatch("fault_level", 64'(m_axis_tdata[197:196]), 64'(want.fault_level));
			if (m_axis_tdata[199:198] !== want.page_size)
				report_mismatch("page_size", 64'(m_axis_tdata[199:198]), 64'(want.page_size));
			if (m_axis_tdata[251:200] !== want.paddr)
				report_mismatch("paddr", 64'(m_axis_tdata[251:200]), 64'(want.paddr));
			if (m_axis_tdata[315:252] !== want.leaf_entry)
				report_mismatch("leaf_entry", m_axis_tdata[315:252], want.leaf_entry);
			if (m_axis_tdata[319:316] !== 4'd0)
				report_mismatch("padding", 64'(m_axis_tdata[319:316]), 64'd0);
			if (m_axis_tlast !== want.last)
				report_mismatch("tlast", 64'(m_axis_tlast), 64'(want.last));
		end
		results_checked++;
	endtask

	// Follow every handshake on the three channels.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_base = '0;
			user_start = '0;
			user_end = '0;
			phase = PH_IDLE;
			held_vaddr = '0;
			held_flags = '0;
			set_req = 1'b0;
			held_entry = '0;
			leaf_large = 1'b0;
			expected_q.delete();
			mismatches = 0;
			results_checked = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ptw_pkg::CFG_TABLE_BASE: table_base = cfg_data[51:0];
					ptw_pkg::CFG_USER_START: user_start = cfg_data;
					ptw_pkg::CFG_USER_END:   user_end = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				predict_walk(s_axis_tuser, s_axis_tdata[63:0], s_axis_tdata[127:64],
					s_axis_tdata[191:128]);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				check_result();
			end
		end
		pending = expected_q.size();
		walk_busy = (phase != PH_IDLE);
		swap_wait = (phase == PH_SWAP);
	end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Page table walker testbench
// Drives lookup and set-permission requests together with table read and
// swap responses mostly shaped as well-formed walks, under random gaps and
// stalls, across several register settings; the checker judges every result.
// ---------------------------------------------------------------------------

module tb;

	localparam int unsigned PHYS_BITS = ptw_pkg::PHYS_ADDR_BITS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEMS_PER_PHASE = 100;

	// How a planned walk ends.
	typedef enum int {STOP_ABSENT, STOP_1G, STOP_2M, STOP_4K} stop_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [191:0] s_axis_tdata = '0;
	logic [1:0]   s_axis_tuser = ptw_pkg::OP_LOOKUP;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [319:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         m_axis_tlast;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [1:0]   cfg_index = ptw_pkg::CFG_TABLE_BASE;
	logic [63:0]  cfg_data = '0;

	int   mismatches;
	int   results_checked;
	int   pending;
	logic walk_busy;
	logic swap_wait;

	// Register values as last written, used to plan set requests.
	logic [51:0] base_copy = '0;
	logic [63:0] range_lo = '0;
	logic [63:0] range_hi = '0;

	int   items_sent = 0;
	int   strays = 0;
	int   settings_used = 0;
	int   cycle_count = 0;
	int   stall_left = 0;
	logic steady_src = 1'b0;
	logic steady_sink = 1'b0;

	page_table_walker_with_permission_update_top #(
		.PHYS_ADDR_BITS(PHYS_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	ptw_checker #(
		.PHYS_ADDR_BITS(PHYS_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.results_checked(results_checked),
		.pending(pending),
		.walk_busy(walk_busy),
		.swap_wait(swap_wait)
	);

	always #5 clk = ~clk;

	// Give up on a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.", cycle_count,
				pending);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Idle length: mostly short, sometimes long.
	function automatic int pick_gap(input int shortest);
		int r;
		r = $urandom_range(99, 0);
		if (r < 70) return $urandom_range(3, shortest);
		if (r < 90) return $urandom_range(8, 4);
		return $urandom_range(30, 12);
	endfunction

	// Result receiver: random stalls unless a steady stretch is on.
	always @(posedge clk) begin
		if (stall_left == 0 && !steady_sink && $urandom_range(99, 0) < 25) begin
			stall_left = pick_gap(1);
		end
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Present one request and wait until the walker takes it; tvalid stays high.
	task automatic push_item(input logic [1:0] op, input logic [63:0] va, input logic [63:0] fl,
			input logic [63:0] md);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {md, fl, va};
		items_sent++;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Random gap between requests; none during a steady stretch.
	task automatic pause_in();
		int n;
		n = (steady_src || $urandom_range(1, 0) == 0) ? 0 : pick_gap(1);
		if (n > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Bring the walker back to idle after a broken sequence.
	task automatic finish_walk();
		forever begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			if (!walk_busy) break;
			push_item(swap_wait ? ptw_pkg::OP_SWAP : ptw_pkg::OP_READ, rand64(), rand64(),
				swap_wait ? rand64() : rand64() & ~64'd1);
		end
	endtask

	// Wait until every result has arrived and the walker has settled.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Write all three registers; only called while the walker is idle.
	task automatic set_config(input logic [63:0] base, input logic [63:0] lo,
			input logic [63:0] hi);
		write_reg(ptw_pkg::CFG_TABLE_BASE, base);
		write_reg(ptw_pkg::CFG_USER_START, lo);
		write_reg(ptw_pkg::CFG_USER_END, hi);
		cfg_valid <= 1'b0;
		base_copy = base[51:0];
		range_lo = lo;
		range_hi = hi;
		settings_used++;
	endtask

	function automatic logic set_allowed(input logic [63:0] va);
		return va >= range_lo && va < range_hi && base_copy[51:12] != '0;
	endfunction

	// Virtual address: sets mostly inside the permitted range, else edges or anything.
	function automatic logic [63:0] pick_va(input logic set_req);
		logic [63:0] span;
		span = range_hi - range_lo;
		if (set_req && range_hi > range_lo && $urandom_range(9, 0) < 8) begin
			case ($urandom_range(3, 0))
				0: return range_lo;
				1: return range_hi - 64'd1;
				default: return range_lo + rand64() % span;
			endcase
		end
		case ($urandom_range(3, 0))
			0: return range_hi;
			1: return range_lo - 64'd1;
			default: return rand64();
		endcase
	endfunction

	// Table entry with chosen present and PS bits; sometimes all ones or all zeros.
	function automatic logic [63:0] make_entry(input logic present, input logic ps);
		logic [63:0] e;
		case ($urandom_range(9, 0))
			0: e = '1;
			1: e = '0;
			default: e = rand64();
		endcase
		e[0] = present;
		e[7] = ps;
		return e;
	endfunction

	// One request followed by the memory responses of a walk ending as planned.
	// Busy requests are slipped in at random while the walk is in flight.
	task automatic run_walk(input logic set_req, input logic [63:0] va, input logic [63:0] fl,
			input stop_t stop, input int absent_lvl, input logic swap_ok, input int noise_pct);
		logic [63:0] ent;
		logic ps;
		int depth;
		push_item(set_req ? ptw_pkg::OP_SET : ptw_pkg::OP_LOOKUP, va, fl, rand64());
		pause_in();
		if (set_req && !set_allowed(va)) return;
		case (stop)
			STOP_ABSENT: depth = absent_lvl;
			STOP_1G: depth = 1;
			STOP_2M: depth = 2;
			default: depth = 3;
		endcase
		ent = '0;
		for (int lvl = 0; lvl <= depth; lvl++) begin
			// PS is ignored at the top and meaningless at the last level.
			ps = (lvl == 0 || lvl == 3) ? 1'($urandom_range(1, 0)) : 1'b0;
			if (lvl == depth && (stop == STOP_1G || stop == STOP_2M)) begin
				ps = 1'b1;
			end
			ent = make_entry(!(lvl == depth && stop == STOP_ABSENT), ps);
			if ($urandom_range(99, 0) < noise_pct) begin
				push_item($urandom_range(1, 0) ? ptw_pkg::OP_SET : ptw_pkg::OP_LOOKUP, rand64(),
					rand64(), rand64());
				pause_in();
			end
			push_item(ptw_pkg::OP_READ, rand64(), rand64(), ent);
			pause_in();
		end
		if (set_req && (stop == STOP_2M || stop == STOP_4K)) begin
			if ($urandom_range(99, 0) < noise_pct) begin
				push_item($urandom_range(1, 0) ? ptw_pkg::OP_SET : ptw_pkg::OP_LOOKUP, rand64(),
					rand64(), rand64());
				pause_in();
			end
			push_item(ptw_pkg::OP_SWAP, rand64(), rand64(),
				swap_ok ? ent : ent ^ (rand64() | 64'd1));
			pause_in();
		end
	endtask

	initial begin
		logic [63:0] b;
		logic [63:0] lo;
		logic [63:0] hi;
		logic set_req;
		stop_t stop;
		int r;
		int target;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: lookups walk from table zero, every set falls outside the empty range.
		push_item(ptw_pkg::OP_LOOKUP, 64'd0, 64'd0, 64'd0);
		pause_in();
		push_item(ptw_pkg::OP_READ, 64'd0, 64'd0, 64'd0);
		pause_in();
		run_walk(1'b1, 64'd0, '1, STOP_4K, 0, 1'b1, 0);
		wait_drained();

		// Widest range and the highest base: each leaf kind, swaps, range edges, strays.
		set_config(64'h000F_FFFF_FFFF_FFFF, 64'd0, '1);
		run_walk(1'b0, '1, '0, STOP_1G, 0, 1'b0, 0);
		run_walk(1'b1, 64'hFFFF_FFFF_FFFF_FFFE, '1, STOP_4K, 0, 1'b1, 0);
		run_walk(1'b1, '1, rand64(), STOP_4K, 0, 1'b1, 0);
		run_walk(1'b1, rand64() >> 1, '0, STOP_2M, 0, 1'b1, 0);
		run_walk(1'b1, rand64() >> 1, rand64(), STOP_1G, 0, 1'b1, 0);
		push_item(ptw_pkg::OP_READ, rand64(), rand64(), '1);
		strays++;
		pause_in();
		push_item(ptw_pkg::OP_SWAP, rand64(), rand64(), rand64());
		strays++;
		wait_drained();

		// Base with only ignored bits set: sets are refused.
		set_config(64'h0000_0000_0000_0FFF, 64'd0, '1);
		run_walk(1'b1, rand64() >> 1, rand64(), STOP_4K, 0, 1'b1, 0);
		wait_drained();

		// Random walks under four settings.
		target = items_sent - strays;
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					b = 64'h0000_0000_0000_1000;
					lo = 64'd0;
					hi = '1;
				end
				1: begin
					b = rand64();
					b[12] = 1'b1;
					lo = rand64() >> 1;
					hi = lo + (64'd1 << $urandom_range(40, 12));
				end
				2: begin
					b = '1;
					lo = rand64();
					hi = rand64();
				end
				default: begin
					b = rand64();
					b[51] = 1'b1;
					lo = 64'd0;
					hi = rand64() | (64'd1 << 63);
				end
			endcase
			set_config(b, lo, hi);
			steady_sink = (p == 3);
			target += ITEMS_PER_PHASE;
			while (items_sent - strays < target) begin
				steady_src = ($urandom_range(9, 0) == 0);
				if ($urandom_range(19, 0) == 0) steady_sink = !steady_sink;
				r = $urandom_range(99, 0);
				if (r < 4) begin
					// Response with nothing outstanding: ignored.
					push_item($urandom_range(1, 0) ? ptw_pkg::OP_READ : ptw_pkg::OP_SWAP, rand64(),
						rand64(), rand64());
					strays++;
					pause_in();
				end else if (r < 8) begin
					// Broken sequence: a few arbitrary items, then finish what they started.
					repeat ($urandom_range(3, 1)) begin
						push_item(2'($urandom_range(3, 0)), rand64(), rand64(), rand64());
						pause_in();
					end
					finish_walk();
				end else begin
					r = $urandom_range(99, 0);
					stop = r < 15 ? STOP_ABSENT : r < 35 ? STOP_1G : r < 65 ? STOP_2M : STOP_4K;
					set_req = 1'($urandom_range(1, 0));
					run_walk(set_req, pick_va(set_req), rand64(), stop, $urandom_range(3, 0),
						$urandom_range(3, 0) != 0, 5);
				end
			end
			wait_drained();
		end

		steady_src = 1'b0;
		wait_drained();
		$display("Sent %0d requests and memory responses (%0d of them stray) under %0d settings.",
			items_sent, strays, settings_used);
		$display("Checked %0d results, %0d mismatches.", results_checked, mismatches);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
